FILE: rtl/go_to_goal_steering_defines.svh
// Assertion macros shared by the go-to-goal steering RTL.
`ifndef GO_TO_GOAL_STEERING_DEFINES_SVH
`define GO_TO_GOAL_STEERING_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GTG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define GTG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gtg_pkg.sv
// Shared constants, types and tables of the go-to-goal steering block.
package gtg_pkg;

	// CORDIC iterations in the bearing path (8 to 24).
	localparam int CORDIC_STEPS = 16;
	localparam int MAX_STEPS    = 24;
	localparam int STEP_W       = $clog2(MAX_STEPS);

	// Offset and square root sizes.
	localparam int DW       = 17;
	localparam int SQ_STEPS = DW;
	localparam int RAD_W    = 2 * SQ_STEPS;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int REM_W    = SQ_STEPS + 2;

	// CORDIC datapath widths.
	localparam int CW = 20;
	localparam int ZW = 24;

	localparam int N_CELLS = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;

	localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic signed [ZW-1:0] BEARING_RND = 24'sd128;

	localparam logic signed [ZW-1:0] ATAN_Q20 [MAX_STEPS] = '{
		24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
		24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
		24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
		24'sd256,    24'sd128,    24'sd64,     24'sd32,
		24'sd16,     24'sd8,      24'sd4,      24'sd2,
		24'sd1,      24'sd0,      24'sd0,      24'sd0
	};

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_THR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT  = 3'd5;

	// Data that travels down the row of cells.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [RAD_W-1:0]     rad;
		logic [REM_W-1:0]     rem;
		logic [ROOT_W-1:0]    root;
		logic signed [15:0]   heading;
	} cell_data_t;

endpackage

FILE: rtl/gtg_cell.sv
// One cell of the chain: a CORDIC vectoring step (below CORDIC_STEPS) and a square root digit (below SQ_STEPS).
module gtg_cell
	import gtg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  logic              adv,
	input  logic              in_v,
	input  cell_data_t        in_d,
	output logic              out_v,
	output cell_data_t        out_d
);

	logic signed [CW-1:0]  x, y, xs, ys;
	logic signed [ZW-1:0]  z;
	logic [REM_W+1:0]      pair_rem, sub, diff;
	cell_data_t            nxt;
	logic                  valid_q;
	cell_data_t            data_q;

	always_comb begin
		x        = in_d.x;
		y        = in_d.y;
		z        = in_d.z;
		xs       = x >>> step;
		ys       = y >>> step;
		pair_rem = {in_d.rem, in_d.rad[RAD_W-1 -: 2]};
		sub      = {{(REM_W-ROOT_W){1'b0}}, in_d.root, 2'b01};
		diff     = pair_rem - sub;
		nxt      = in_d;

		if (int'(step) < CORDIC_STEPS) begin
			if (y > 0) begin
				nxt.x = x + ys;
				nxt.y = y - xs;
				nxt.z = z + ATAN_Q20[step];
			end else begin
				nxt.x = x - ys;
				nxt.y = y + xs;
				nxt.z = z - ATAN_Q20[step];
			end
		end

		if (int'(step) < SQ_STEPS) begin
			nxt.rad = {in_d.rad[RAD_W-3:0], 2'b00};
			if (pair_rem >= sub) begin
				nxt.rem  = diff[REM_W-1:0];
				nxt.root = {in_d.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = pair_rem[REM_W-1:0];
				nxt.root = {in_d.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	assign out_v = valid_q;
	assign out_d = data_q;

endmodule

FILE: rtl/gtg_front.sv
// Front stages: goal offset, squares with quadrant pre-rotation, radicand sum.
module gtg_front
	import gtg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         adv,
	input  logic               in_valid,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] heading,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	output logic [2:0]         stage_v,
	output cell_data_t         dat
);

	logic signed [DW-1:0]   dx_s1, dy_s1;
	logic signed [15:0]     hd_s1, hd_s2;
	logic                   v_s1, v_s2, v_s3;
	logic signed [2*DW-1:0] sqx, sqy;
	logic [RAD_W-2:0]       sqx_s2, sqy_s2;
	logic signed [CW-1:0]   x0, y0, x_s2, y_s2;
	logic signed [ZW-1:0]   z0, z_s2;
	cell_data_t             dat_s3;

	always_comb begin
		sqx = dx_s1 * dx_s1;
		sqy = dy_s1 * dy_s1;
		x0  = CW'(dx_s1);
		y0  = CW'(dy_s1);
		z0  = '0;
		// A vector in the left half plane is turned by a quarter turn first.
		if (dx_s1 < 0) begin
			if (dy_s1 >= 0) begin
				x0 = CW'(dy_s1);
				y0 = -CW'(dx_s1);
				z0 = HALF_PI_Q20;
			end else begin
				x0 = -CW'(dy_s1);
				y0 = CW'(dx_s1);
				z0 = -HALF_PI_Q20;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv[0]) v_s1 <= in_valid;
			if (adv[1]) v_s2 <= v_s1;
			if (adv[2]) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dx_s1 <= DW'(target_x) - DW'(pos_x);
			dy_s1 <= DW'(target_y) - DW'(pos_y);
			hd_s1 <= heading;
		end
		if (adv[1]) begin
			sqx_s2 <= sqx[RAD_W-2:0];
			sqy_s2 <= sqy[RAD_W-2:0];
			x_s2   <= x0;
			y_s2   <= y0;
			z_s2   <= z0;
			hd_s2  <= hd_s1;
		end
		if (adv[2]) begin
			dat_s3.x       <= x_s2;
			dat_s3.y       <= y_s2;
			dat_s3.z       <= z_s2;
			dat_s3.rad     <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			dat_s3.rem     <= '0;
			dat_s3.root    <= '0;
			dat_s3.heading <= hd_s2;
		end
	end

	assign stage_v = {v_s3, v_s2, v_s1};
	assign dat     = dat_s3;

endmodule

FILE: rtl/gtg_back.sv
// Back stages: bearing rounding, heading error, clamp, speed and output register.
module gtg_back
	import gtg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         adv,
	input  logic               in_v,
	input  cell_data_t         in_d,
	input  logic [11:0]        speed_gain,
	input  logic [14:0]        speed_limit,
	input  logic [14:0]        arrive_threshold,
	input  logic [14:0]        angle_limit,
	output logic [1:0]         stage_v,
	output logic signed [15:0] turn_rate,
	output logic [14:0]        forward_speed
);

	localparam int PROD_W = ROOT_W + 12;

	logic signed [ZW-1:0] zr;
	logic signed [15:0]   bearing;
	logic signed [DW-1:0] err_s1, lim, nlim, turn;
	logic                 arrived_s1, v_s1, v_s2;
	logic [PROD_W-1:0]    prod_s1;
	logic [PROD_W-9:0]    spd;
	logic [14:0]          spd_sat;
	logic                 in_range;
	logic signed [15:0]   turn_s2;
	logic [14:0]          speed_s2;

	always_comb begin
		zr      = in_d.z + BEARING_RND;
		bearing = zr[ZW-1:8];
	end

	always_comb begin
		lim      = DW'($signed({1'b0, angle_limit}));
		nlim     = -lim;
		turn     = err_s1;
		if (err_s1 > lim) begin
			turn = lim;
		end else if (err_s1 < nlim) begin
			turn = nlim;
		end
		in_range = (err_s1 < lim) && (err_s1 > nlim);
		spd      = prod_s1[PROD_W-1:8];
		spd_sat  = (spd > (PROD_W-8)'(speed_limit)) ? speed_limit : spd[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv[0]) v_s1 <= in_v;
			if (adv[1]) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			err_s1     <= DW'(bearing) - DW'(in_d.heading);
			arrived_s1 <= in_d.root <= ROOT_W'(arrive_threshold);
			prod_s1    <= PROD_W'(in_d.root) * PROD_W'(speed_gain);
		end
		if (adv[1]) begin
			if (arrived_s1) begin
				turn_s2  <= '0;
				speed_s2 <= '0;
			end else begin
				turn_s2  <= turn[15:0];
				speed_s2 <= in_range ? spd_sat : 15'd0;
			end
		end
	end

	assign stage_v       = {v_s2, v_s1};
	assign turn_rate     = turn_s2;
	assign forward_speed = speed_s2;

endmodule

FILE: rtl/go_to_goal_steering.sv
// Top level of the go-to-goal steering controller.
// Go-to-goal steering: each pose transaction (pos_x, pos_y in Q6.10, heading
// in Q3.12 radians) yields exactly one result transaction with a turn rate
// (Q3.12) and a forward speed (unsigned Q5.10) that steer the robot toward
// the goal held in the configuration registers. The block takes one pose per
// clock cycle while in_stall is low. The pipeline has three front stages
// (goal offset, squares with quadrant pre-rotation, radicand sum), a row of
// 17 cells and two back stages. The cell count is the number of root bits of
// the 17-bit distance; each cell settles one root bit and, in the first 16
// cells, one CORDIC vectoring iteration of the bearing. Every stage advances
// independently, so bubbles close up and in_stall rises only when all stages
// hold work and the output register is stalled. When the distance is at or
// below arrive_threshold, both outputs are zero. Otherwise turn_rate is the
// unwrapped heading error clamped to plus or minus angle_limit, and
// forward_speed is distance times speed_gain (Q4.8), limited to speed_limit,
// only while the error lies strictly inside the limit. Registers are written
// with cfg_wen, cfg_idx and cfg_wdata; the user must write them only while no
// transaction is in flight, as the block itself does not enforce this. Index
// 0 is target_x, 1 target_y, 2 speed_gain, 3 speed_limit, 4 arrive_threshold,
// 5 angle_limit, and writes to other indexes are dropped.
`include "go_to_goal_steering_defines.svh"

module go_to_goal_steering
	import gtg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   pos_x,
	input  logic signed [15:0]   pos_y,
	input  logic signed [15:0]   heading,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   turn_rate,
	output logic [14:0]          forward_speed
);

	// Stage numbering: front stages, then the cells, then the back stages.
	localparam int FRONT_N = 3;
	localparam int BACK_N  = 2;
	localparam int NST     = FRONT_N + N_CELLS + BACK_N;

	// Configuration registers.
	logic signed [15:0] target_x_q, target_y_q;
	logic [11:0]        speed_gain_q;
	logic [14:0]        speed_limit_q, arrive_thr_q, angle_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q    <= 16'sd3072;
			target_y_q    <= 16'sd1024;
			speed_gain_q  <= 12'd512;
			speed_limit_q <= 15'd2048;
			arrive_thr_q  <= 15'd51;
			angle_limit_q <= 15'd819;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_TARGET_X:    target_x_q    <= cfg_wdata;
				REG_TARGET_Y:    target_y_q    <= cfg_wdata;
				REG_SPEED_GAIN:  speed_gain_q  <= cfg_wdata[11:0];
				REG_SPEED_LIMIT: speed_limit_q <= cfg_wdata[14:0];
				REG_ARRIVE_THR:  arrive_thr_q  <= cfg_wdata[14:0];
				REG_ANGLE_LIMIT: angle_limit_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// Per-stage valid bits and advance enables. A stage may load when it is
	// empty or when the stage after it loads in the same cycle.
	logic [NST-1:0] stage_v;
	logic [NST-1:0] adv;

	assign adv[NST-1] = !stage_v[NST-1] || !out_stall;

	for (genvar k = 0; k < NST - 1; k++) begin : g_adv
		assign adv[k] = !stage_v[k] || adv[k+1];
	end

	assign in_stall = !adv[0];

	// Front stages.
	cell_data_t cell_d [N_CELLS+1];
	logic [N_CELLS:0] cell_v;

	gtg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv[FRONT_N-1:0]),
		.in_valid (in_valid),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.heading  (heading),
		.target_x (target_x_q),
		.target_y (target_y_q),
		.stage_v  (stage_v[FRONT_N-1:0]),
		.dat      (cell_d[0])
	);

	assign cell_v[0] = stage_v[FRONT_N-1];

	// Row of cells; each one hands its result to the next whenever that one advances.
	for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
		gtg_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (STEP_W'(k)),
			.adv    (adv[FRONT_N+k]),
			.in_v   (cell_v[k]),
			.in_d   (cell_d[k]),
			.out_v  (cell_v[k+1]),
			.out_d  (cell_d[k+1])
		);
		assign stage_v[FRONT_N+k] = cell_v[k+1];
	end

	// Back stages and output register.
	gtg_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv[NST-1 -: BACK_N]),
		.in_v             (cell_v[N_CELLS]),
		.in_d             (cell_d[N_CELLS]),
		.speed_gain       (speed_gain_q),
		.speed_limit      (speed_limit_q),
		.arrive_threshold (arrive_thr_q),
		.angle_limit      (angle_limit_q),
		.stage_v          (stage_v[NST-1 -: BACK_N]),
		.turn_rate        (turn_rate),
		.forward_speed    (forward_speed)
	);

	assign out_valid = stage_v[NST-1];

	// The input side is held off only when every stage is full and the output
	// transaction is stalled.
	`GTG_ASSERT_IMP(a_stall_needs_full, in_stall, out_valid && out_stall, "in_stall without blocked output")
	// A new result only appears in the output register when the stage before it held one.
	`GTG_ASSERT_IMP(a_out_from_back, $rose(out_valid), $past(stage_v[NST-2]), "result appeared from an empty stage")
	// The last cell keeps its transaction while the stage after it cannot load.
	`GTG_ASSERT_NXT(a_cell_holds, cell_v[N_CELLS] && !adv[FRONT_N+N_CELLS], cell_v[N_CELLS], "cell dropped a stalled transaction")

endmodule
